### hdl/s2a_pkg.sv
package s2a_pkg;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] RELEASE_LIMIT = 8'h80;
   localparam logic [7:0] UNKNOWN_CHAR  = 8'h3F;

   localparam int DATA_W = 8;
   localparam int FILL_W = 9;

   typedef struct packed {
      logic push;
      logic miss;
      logic pop;
   } s2a_cmd_type;

   typedef struct packed {
      logic empty;
   } s2a_stat_type;

   function automatic logic [7:0] translate(input logic [7:0] code);
      logic [7:0] ch;
      ch = UNKNOWN_CHAR;
      unique case (code)
         8'h02: ch = "1";
         8'h03: ch = "2";
         8'h04: ch = "3";
         8'h05: ch = "4";
         8'h06: ch = "5";
         8'h07: ch = "6";
         8'h08: ch = "7";
         8'h09: ch = "8";
         8'h0A: ch = "9";
         8'h0B: ch = "0";
         8'h0E: ch = 8'h08;
         8'h10: ch = "q";
         8'h11: ch = "w";
         8'h12: ch = "e";
         8'h13: ch = "r";
         8'h14: ch = "t";
         8'h15: ch = "y";
         8'h16: ch = "u";
         8'h17: ch = "i";
         8'h18: ch = "o";
         8'h19: ch = "p";
         8'h1C: ch = 8'h0A;
         8'h1E: ch = "a";
         8'h1F: ch = "s";
         8'h20: ch = "d";
         8'h21: ch = "f";
         8'h22: ch = "g";
         8'h23: ch = "h";
         8'h24: ch = "j";
         8'h25: ch = "k";
         8'h26: ch = "l";
         8'h2C: ch = "z";
         8'h2D: ch = "x";
         8'h2E: ch = "c";
         8'h2F: ch = "v";
         8'h30: ch = "b";
         8'h31: ch = "n";
         8'h32: ch = "m";
         8'h39: ch = " ";
         default: ch = UNKNOWN_CHAR;
      endcase
      return ch;
   endfunction

endpackage

### hdl/s2a_ctrl.sv
module s2a_ctrl
   import s2a_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_op,
   input  logic         rsp_tready,
   input  s2a_stat_type stat,
   output logic         req_tready,
   output logic         rsp_tvalid,
   output s2a_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_RESP  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.push = accept && (req_op == OP_SCAN);
      cmd.miss = accept && (req_op == OP_READ) && stat.empty;
      cmd.pop  = (state_ff == ST_FETCH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_op == OP_READ) && !stat.empty) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/s2a_datapath.sv
module s2a_datapath
   import s2a_pkg::*;
#(
   parameter int FIFO_DEPTH = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  s2a_cmd_type        cmd,
   input  logic [7:0]         scancode_in,
   output s2a_stat_type       stat,
   output logic [DATA_W-1:0]  char_out,
   output logic               char_valid,
   output logic               stored,
   output logic [FILL_W-1:0]  fill_level
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [DATA_W-1:0] mem [FIFO_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic [CW:0]   wr_sum;
   logic [CW:0]   wr_wrap;
   logic [AW-1:0] wr_addr;
   logic          do_push;
   logic [7:0]    push_char;
   logic [CW+FILL_W-1:0] fill_ext;

   logic [DATA_W-1:0] char_out_ff;
   logic [DATA_W-1:0] char_out_in;
   logic              char_valid_ff;
   logic              char_valid_in;
   logic              stored_ff;
   logic              stored_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_sum  = (CW+1)'(rd_ptr_ff) + (CW+1)'(count_ff);
      wr_wrap = wr_sum;
      if (wr_sum >= (CW+1)'(FIFO_DEPTH)) begin
         wr_wrap = wr_sum - (CW+1)'(FIFO_DEPTH);
      end
      wr_addr   = wr_wrap[AW-1:0];
      push_char = translate(scancode_in);
      do_push   = cmd.push && (scancode_in <= RELEASE_LIMIT)
                  && (count_ff < CW'(FIFO_DEPTH));
   end

   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      char_out_in   = char_out_ff;
      char_valid_in = char_valid_ff;
      stored_in     = stored_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         if (rd_ptr_ff == AW'(FIFO_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + AW'(1);
         end
      end
      if (cmd.push || cmd.miss) begin
         char_out_in   = '0;
         char_valid_in = 1'b0;
         stored_in     = do_push;
      end
      if (cmd.pop) begin
         char_out_in   = rd_data_ff;
         char_valid_in = 1'b1;
         stored_in     = 1'b0;
      end
      fill_ext = {{FILL_W{1'b0}}, count_in};
      fill_in  = fill_ff;
      if (cmd.push || cmd.miss || cmd.pop) begin
         fill_in = fill_ext[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_addr] <= push_char;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      char_out_ff   <= char_out_in;
      char_valid_ff <= char_valid_in;
      stored_ff     <= stored_in;
      fill_ff       <= fill_in;
   end

   assign char_out   = char_out_ff;
   assign char_valid = char_valid_ff;
   assign stored     = stored_ff;
   assign fill_level = fill_ff;

endmodule

### hdl/scancode_to_ascii_fifo.sv
// Set-1 scan code to ASCII translator with a character FIFO.
// Request channel (req_): req_tuser is the opcode, 0 = scan code event,
// 1 = read one character; req_tdata carries the scan code byte.
// Response channel (rsp_): exactly one response per request. rsp_tdata
// holds the popped character and the FIFO fill level after the request;
// rsp_tuser flags a returned character and a stored character.
// Key releases (codes above 0x80) store nothing; a full FIFO drops the new
// character; a read of an empty FIFO returns char_valid = 0.
// A scan code or an empty read gives rsp_tvalid in the cycle after
// acceptance; a read of a held character passes through ST_FETCH first,
// for the registered read port of the character memory.
// One request is in flight at a time: a new request is taken only after
// the response to the last one has been delivered.
// A stalled response holds rsp_tdata/rsp_tuser and keeps req_tready low.
// Reset empties the FIFO at once; memory contents are not cleared.
module scancode_to_ascii_fifo
   import s2a_pkg::*;
#(
   parameter int FIFO_DEPTH = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scancode_in
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_out, [16:8] fill_level, zero pad
   output logic [1:0]  rsp_tuser    // [0] char_valid, [1] stored
);

   s2a_cmd_type       cmd;
   s2a_stat_type      stat;
   logic [DATA_W-1:0] char_out;
   logic              char_valid;
   logic              stored;
   logic [FILL_W-1:0] fill_level;

   s2a_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   s2a_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .scancode_in (req_tdata),
      .stat        (stat),
      .char_out    (char_out),
      .char_valid  (char_valid),
      .stored      (stored),
      .fill_level  (fill_level)
   );

   assign rsp_tdata = {7'd0, fill_level, char_out};
   assign rsp_tuser = {stored, char_valid};

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("char_valid and stored both set");

   a_stored_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[16:8] != 9'd0))
      else $error("stored character but fill level is zero");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("not ready after response delivered");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.miss, cmd.pop}))
      else $error("more than one datapath command at once");

endmodule

### tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import s2a_pkg::*;

   localparam int RING_DEPTH = 256;

   typedef struct {
      logic [DATA_W-1:0] ch;
      logic              valid;
      logic              stored;
      logic [FILL_W-1:0] fill;
   } key_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] scancode_in
   logic        req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // [7:0] char_out, [16:8] fill_level, zero pad
   logic [1:0]  rsp_tuser;   // [0] char_valid, [1] stored

   key_result_type    pending_results[$];
   logic [DATA_W-1:0] ring_chars [RING_DEPTH];
   int                ring_head;
   int                ring_count;
   int                fail_count;
   bit                steady_flow;

   scancode_to_ascii_fifo #(
      .FIFO_DEPTH (RING_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // set-1 layout: digit row, three letter rows, plus backspace/enter/space
   function automatic logic [7:0] key_to_ascii(logic [7:0] code);
      string digit_row  = "1234567890";
      string upper_row  = "qwertyuiop";
      string home_row   = "asdfghjkl";
      string bottom_row = "zxcvbnm";
      logic [7:0] ascii;
      ascii = UNKNOWN_CHAR;
      if (code >= 8'h02 && code <= 8'h0B) begin
         ascii = digit_row[int'(code) - 'h02];
      end else if (code >= 8'h10 && code <= 8'h19) begin
         ascii = upper_row[int'(code) - 'h10];
      end else if (code >= 8'h1E && code <= 8'h26) begin
         ascii = home_row[int'(code) - 'h1E];
      end else if (code >= 8'h2C && code <= 8'h32) begin
         ascii = bottom_row[int'(code) - 'h2C];
      end else if (code == 8'h0E) begin
         ascii = 8'h08;
      end else if (code == 8'h1C) begin
         ascii = 8'h0A;
      end else if (code == 8'h39) begin
         ascii = 8'h20;
      end
      return ascii;
   endfunction

   function automatic key_result_type predict_request(logic op, logic [7:0] code);
      key_result_type r;
      r.ch     = '0;
      r.valid  = 1'b0;
      r.stored = 1'b0;
      if (op == OP_SCAN) begin
         if (code <= RELEASE_LIMIT && ring_count < RING_DEPTH) begin
            ring_chars[(ring_head + ring_count) % RING_DEPTH] = key_to_ascii(code);
            ring_count++;
            r.stored = 1'b1;
         end
      end else if (ring_count != 0) begin
         r.ch      = ring_chars[ring_head];
         ring_head = (ring_head + 1) % RING_DEPTH;
         ring_count--;
         r.valid   = 1'b1;
      end
      r.fill = FILL_W'(ring_count);
      return r;
   endfunction

   function automatic logic [7:0] random_scancode();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return 8'($urandom_range(8'h39, 8'h02));
      end else if (pick < 85) begin
         return 8'($urandom_range(RELEASE_LIMIT, 0));
      end
      return 8'($urandom_range(255, 0));
   endfunction

   task automatic send_request(logic op, logic [7:0] code);
      while (!steady_flow && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_request(op, code));
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= 29);
   end

   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      key_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no pending request", $time);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("char_out", 16'(want.ch), 16'(rsp_tdata[7:0]));
            check_field("fill_level", 16'(want.fill), 16'(rsp_tdata[16:8]));
            check_field("char_valid", 16'(want.valid), 16'(rsp_tuser[0]));
            check_field("stored", 16'(want.stored), 16'(rsp_tuser[1]));
         end
      end
   end

   // empty read, release boundary, special keys, unmapped codes, drain
   task automatic test_directed();
      logic [7:0] codes [12] = '{8'h00, 8'hFF, 8'h80, 8'h81, 8'h02, 8'h0E,
                                 8'h1C, 8'h39, 8'h32, 8'h3A, 8'h7F, 8'hAA};
      send_request(OP_READ, 8'h00);
      foreach (codes[i]) send_request(OP_SCAN, codes[i]);
      while (ring_count > 0) send_request(OP_READ, 8'hFF);
      send_request(OP_READ, 8'h5A);
   endtask

   // fill past full so characters drop, then drain through the wrap
   task automatic test_fill_and_drain();
      while (ring_count < RING_DEPTH) send_request(OP_SCAN, random_scancode());
      repeat (6) send_request(OP_SCAN, 8'($urandom_range(RELEASE_LIMIT, 0)));
      steady_flow = 1'b1;
      while (ring_count > RING_DEPTH / 2) send_request(OP_READ, 8'($urandom));
      steady_flow = 1'b0;
      while (ring_count > 0) send_request(OP_READ, 8'($urandom));
      repeat (2) send_request(OP_READ, 8'($urandom));
   endtask

   task automatic test_random_traffic(int count);
      int read_pct;
      for (int i = 0; i < count; i++) begin
         steady_flow = (i >= count / 3) && (i < count / 2);
         read_pct    = ((i / 20) % 2 == 0) ? 35 : 65;
         if ($urandom_range(99) < read_pct) begin
            send_request(OP_READ, 8'($urandom));
         end else begin
            send_request(OP_SCAN, random_scancode());
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = OP_SCAN;
      req_tdata   = '0;
      ring_head   = 0;
      ring_count  = 0;
      fail_count  = 0;
      steady_flow = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_random_traffic(40);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
